// ===== hw/rtl/dtt_pkg.sv =====
// Shared constants, types and codes of the dirty tile tracker.
package dtt_pkg;

  // grid limits
  localparam int MAX_TILES_X = 64;
  localparam int MAX_TILES_Y = 64;

  // column / row index widths and tile count widths
  localparam int COL_W  = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
  localparam int ROW_W  = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
  localparam int NCOL_W = $clog2(MAX_TILES_X + 1);
  localparam int NROW_W = $clog2(MAX_TILES_Y + 1);

  // divider operand widths: pixel span plus tile size, tile size
  localparam int DIV_N = 15;
  localparam int DIV_D = 9;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_CLR = 2'd2,
    OP_GET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_CW = 2'd0,
    REG_CH = 2'd1,
    REG_TW = 2'd2,
    REG_TH = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CLIP,
    F_DIV_GO,
    F_DIV_WAIT,
    F_PUSH
  } fstate_t;

  typedef enum logic [2:0] {
    S_COLS,
    S_ROWS,
    S_C1,
    S_C2,
    S_R1,
    S_R2
  } step_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MK_RD,
    B_MK_WR,
    B_SC_RD,
    B_SC_EV,
    B_DN_CHK,
    B_DN_RD,
    B_DN_EV,
    B_GET_FIN,
    B_RES
  } bstate_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quot;
  } div_rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic              ok;
    logic [COL_W-1:0]  c1;
    logic [COL_W-1:0]  c2;
    logic [ROW_W-1:0]  r1;
    logic [ROW_W-1:0]  r2;
    logic [NCOL_W-1:0] cols;
    logic [NROW_W-1:0] rows;
    logic [8:0]        tw;
    logic [8:0]        th;
  } cmd_t;

endpackage

// ===== hw/rtl/dirty_tile_tracker_core.sv =====
// Add/delete: the front runs six divisions on the shared divider, then the back
// reads and writes each touched tile row; clear and get run two front divisions,
// and get then scans rows and merges the rows below the first dirty run.
// The front takes a new word only when idle; a two-entry queue lets it work ahead
// of the back's row walk.
// Reset (rst_n low, synchronous): registers to 640/480/32/32, bitmap clean at once
// through per-row valid bits, queue and output empty; no clearing pass.
module dirty_tile_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  // input: tdata = rect_x, rect_y, rect_w, rect_h (16 bits each, lowest first)
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // tuser = operation
  input  logic [1:0]  in_tuser,
  // result: tdata = tile_count[12:0], out_x[26:13], out_y[40:27],
  //         out_w[55:41], out_h[70:56], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  // tuser = found
  output logic        out_tuser,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dtt_pkg::*;

  logic [13:0] cw_r, ch_r;
  logic [8:0]  tw_r, th_r;
  reg_t        sel;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  cmd_t        f_cmd, b_cmd;
  logic        push, full, pop, empty;

  assign sel        = reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 14'd640;
      ch_r <= 14'd480;
      tw_r <= 9'd32;
      th_r <= 9'd32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (sel)
        REG_CW:  cw_r <= cfg_pwdata[13:0];
        REG_CH:  ch_r <= cfg_pwdata[13:0];
        REG_TW:  tw_r <= cfg_pwdata[8:0];
        REG_TH:  th_r <= cfg_pwdata[8:0];
        default: cw_r <= cw_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (sel)
      REG_CW:  cfg_prdata = 32'(cw_r);
      REG_CH:  cfg_prdata = 32'(ch_r);
      REG_TW:  cfg_prdata = 32'(tw_r);
      REG_TH:  cfg_prdata = 32'(th_r);
      default: cfg_prdata = '0;
    endcase
  end

  dtt_div u_div (
    .clk (clk), .rst_n (rst_n), .req (div_req), .rsp (div_rsp)
  );

  dtt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cw        (cw_r),
    .ch        (ch_r),
    .tw        (tw_r),
    .th        (th_r),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .push      (push),
    .cmd       (f_cmd),
    .full      (full)
  );

  dtt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (f_cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (b_cmd),
    .empty     (empty)
  );

  dtt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (b_cmd),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/dtt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module dtt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dtt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dtt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dtt_pkg::div_req_t req,
  output dtt_pkg::div_rsp_t rsp
);
  import dtt_pkg::*;

  localparam int CW = $clog2(DIV_N);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_D-1:0] rem_r;
  logic [DIV_N-1:0] quo_r;
  logic [DIV_D-1:0] dvs_r;
  logic [DIV_D+1:0] trial;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem_r, quo_r[DIV_N-1]} - {2'b00, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_N - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      if (!trial[DIV_D+1]) begin
        rem_r <= trial[DIV_D-1:0];
        quo_r <= {quo_r[DIV_N-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DIV_D-2:0], quo_r[DIV_N-1]};
        quo_r <= {quo_r[DIV_N-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ===== hw/rtl/dtt_front.sv =====
// Front end: accepts words, clips rectangles and works out tile spans.
module dtt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  input  logic [63:0]       in_tdata,
  input  logic [13:0]       cw,
  input  logic [13:0]       ch,
  input  logic [8:0]        tw,
  input  logic [8:0]        th,
  output dtt_pkg::div_req_t div_req,
  input  dtt_pkg::div_rsp_t div_rsp,
  output logic              push,
  output dtt_pkg::cmd_t     cmd,
  input  logic              full
);
  import dtt_pkg::*;

  typedef struct packed {
    logic        nil;
    logic [13:0] lo;
    logic [13:0] hi;
  } clip_t;

  typedef struct packed {
    logic             fail;
    logic [DIV_N-1:0] f;
    logic [DIV_N-1:0] l;
  } span_t;

  fstate_t state_r, state_nxt;
  step_t   step_r;
  op_t     op_r;

  logic signed [15:0] rx_r, ry_r, rw_r, rh_r;
  clip_t              xc_r, yc_r;
  logic [DIV_N-1:0]   qcols_r, qrows_r, qc1_r, qc2_r, qr1_r, qr2_r;
  logic [8:0]         tws, ths;
  logic               del;
  logic               last_step;
  logic [DIV_N-1:0]   ncols, nrows;
  span_t              xs, ys;

  // clip [pos, pos+len) to [0, limit)
  function automatic clip_t clip_f(input logic signed [15:0] pos,
                                   input logic signed [15:0] len,
                                   input logic [13:0] limit);
    logic signed [16:0] a;
    logic signed [16:0] b;
    clip_t r;
    a = pos[15] ? 17'sd0 : $signed({1'b0, pos});
    b = $signed({pos[15], pos}) + $signed({len[15], len});
    if (b > $signed({3'b000, limit})) begin
      b = $signed({3'b000, limit});
    end
    r.nil = (len <= 16'sd0) || (b <= a);
    r.lo  = a[13:0];
    r.hi  = b[13:0];
    return r;
  endfunction

  // tile span inside a grid of n tiles from the two quotients
  function automatic span_t span_f(input logic nil, input logic full_cov,
                                   input logic [DIV_N-1:0] qf,
                                   input logic [DIV_N-1:0] ql,
                                   input logic [DIV_N-1:0] n);
    span_t s;
    s.f    = qf;
    s.l    = full_cov ? ql - 1'b1 : ql;
    s.fail = nil || (full_cov && ql == '0) || n == '0 || s.f > s.l || s.f >= n;
    if (s.l >= n) begin
      s.l = n - 1'b1;
    end
    return s;
  endfunction

  assign tws = (tw == '0) ? 9'd1 : tw;
  assign ths = (th == '0) ? 9'd1 : th;
  assign del = (op_r == OP_DEL);

  // only add and delete need the rectangle spans
  assign last_step = (op_r == OP_ADD || op_r == OP_DEL) ? (step_r == S_R2)
                                                        : (step_r == S_ROWS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:     if (in_tvalid) state_nxt = F_CLIP;
      F_CLIP:     state_nxt = F_DIV_GO;
      F_DIV_GO:   state_nxt = F_DIV_WAIT;
      F_DIV_WAIT: if (div_rsp.done) state_nxt = last_step ? F_PUSH : F_DIV_GO;
      F_PUSH:     if (!full) state_nxt = F_IDLE;
      default:    state_nxt = F_IDLE;
    endcase
  end

  // outputs: handshake and divider operands
  always_comb begin
    in_tready        = (state_r == F_IDLE);
    push             = (state_r == F_PUSH) && !full;
    div_req.start    = (state_r == F_DIV_GO);
    div_req.divisor  = tws;
    div_req.dividend = '0;
    unique case (step_r)
      S_COLS: div_req.dividend = DIV_N'(cw) + DIV_N'(tws) - 1'b1;
      S_ROWS: begin
        div_req.dividend = DIV_N'(ch) + DIV_N'(ths) - 1'b1;
        div_req.divisor  = ths;
      end
      S_C1: div_req.dividend = del ? DIV_N'(xc_r.lo) + DIV_N'(tws) - 1'b1
                                   : DIV_N'(xc_r.lo);
      S_C2: div_req.dividend = del ? DIV_N'(xc_r.hi) : DIV_N'(xc_r.hi) - 1'b1;
      S_R1: begin
        div_req.dividend = del ? DIV_N'(yc_r.lo) + DIV_N'(ths) - 1'b1
                               : DIV_N'(yc_r.lo);
        div_req.divisor  = ths;
      end
      S_R2: begin
        div_req.dividend = del ? DIV_N'(yc_r.hi) : DIV_N'(yc_r.hi) - 1'b1;
        div_req.divisor  = ths;
      end
      default: div_req.dividend = '0;
    endcase
  end

  // cap the grid and build the command
  assign ncols = (qcols_r > DIV_N'(MAX_TILES_X)) ? DIV_N'(MAX_TILES_X) : qcols_r;
  assign nrows = (qrows_r > DIV_N'(MAX_TILES_Y)) ? DIV_N'(MAX_TILES_Y) : qrows_r;
  assign xs    = span_f(xc_r.nil, del, qc1_r, qc2_r, ncols);
  assign ys    = span_f(yc_r.nil, del, qr1_r, qr2_r, nrows);

  always_comb begin
    cmd.op   = op_r;
    cmd.ok   = !xs.fail && !ys.fail;
    cmd.c1   = xs.f[COL_W-1:0];
    cmd.c2   = xs.l[COL_W-1:0];
    cmd.r1   = ys.f[ROW_W-1:0];
    cmd.r2   = ys.l[ROW_W-1:0];
    cmd.cols = ncols[NCOL_W-1:0];
    cmd.rows = nrows[NROW_W-1:0];
    cmd.tw   = tws;
    cmd.th   = ths;
  end

  // state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= S_COLS;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_IDLE) begin
        step_r <= S_COLS;
      end else if (state_r == F_DIV_WAIT && div_rsp.done && !last_step) begin
        step_r <= step_t'(step_r + 1'b1);
      end
    end
  end

  // capture word, clip, store quotients
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_tvalid) begin
      op_r <= op_t'(in_tuser);
      rx_r <= in_tdata[15:0];
      ry_r <= in_tdata[31:16];
      rw_r <= in_tdata[47:32];
      rh_r <= in_tdata[63:48];
    end
    if (state_r == F_CLIP) begin
      xc_r <= clip_f(rx_r, rw_r, cw);
      yc_r <= clip_f(ry_r, rh_r, ch);
    end
    if (state_r == F_DIV_WAIT && div_rsp.done) begin
      unique case (step_r)
        S_COLS:  qcols_r <= div_rsp.quot;
        S_ROWS:  qrows_r <= div_rsp.quot;
        S_C1:    qc1_r   <= div_rsp.quot;
        S_C2:    qc2_r   <= div_rsp.quot;
        S_R1:    qr1_r   <= div_rsp.quot;
        S_R2:    qr2_r   <= div_rsp.quot;
        default: qcols_r <= div_rsp.quot;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dtt_fifo.sv =====
// Two-entry command queue between front and back.
module dtt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dtt_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dtt_pkg::cmd_t pop_data,
  output logic          empty
);
  import dtt_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== hw/rtl/dtt_back.sv =====
// Back end: walks bitmap rows for each command and forms the result word.
module dtt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  dtt_pkg::cmd_t cmd,
  input  logic          empty,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [71:0]   out_tdata,
  output logic          out_tuser
);
  import dtt_pkg::*;

  localparam int XW = MAX_TILES_X;

  bstate_t state_r, state_nxt;
  cmd_t    cmd_r;

  logic [ROW_W-1:0]  row_r;
  logic [NROW_W-1:0] yy_r;
  logic [XW-1:0]     m_r;
  logic [XW-1:0]     low_r;
  logic [XW:0]       end_r;
  logic [COL_W-1:0]  x_r;
  logic [NCOL_W-1:0] xx_r;
  logic              found_r;
  logic [MAX_TILES_Y-1:0] vld_r;
  logic              rd_vld_r;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr, ram_raddr;
  logic [XW-1:0]     ram_wdata, ram_rdata;
  logic [XW-1:0]     row_data, colmask, mk, vis, low, run;
  logic [XW:0]       sum;
  logic [ROW_W-1:0]  dn_addr;
  logic              res_go;

  logic              ov_r;
  logic [12:0]       cnt_o_r;
  logic [13:0]       x_o_r, y_o_r;
  logic [14:0]       w_o_r, h_o_r;
  logic              f_o_r;

  logic [NCOL_W-1:0]        nc;
  logic [NROW_W-1:0]        nr;
  logic [NCOL_W+NROW_W-1:0] prod;
  logic [COL_W+8:0]         px;
  logic [ROW_W+8:0]         py;
  logic [NCOL_W+8:0]        pw;
  logic [NROW_W+8:0]        ph;

  function automatic logic [31:0] sat32(input logic [31:0] v, input logic [31:0] m);
    return (v > m) ? m : v;
  endfunction

  // position of the single set bit
  function automatic logic [NCOL_W-1:0] enc(input logic [XW:0] v);
    logic [NCOL_W-1:0] idx;
    idx = '0;
    for (int i = 0; i <= XW; i++) begin
      if (v[i]) idx = idx | NCOL_W'(i);
    end
    return idx;
  endfunction

  dtt_ram #(.WIDTH(XW), .DEPTH(MAX_TILES_Y)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // row read back; rows not written since reset or the last clear read as clean
  assign row_data = rd_vld_r ? ram_rdata : '0;

  // column masks
  always_comb begin
    for (int i = 0; i < XW; i++) begin
      colmask[i] = (NCOL_W'(i) < cmd_r.cols);
      mk[i]      = (COL_W'(i) >= cmd_r.c1) && (COL_W'(i) <= cmd_r.c2);
    end
  end

  // first dirty run of the scanned row
  assign vis = row_data & colmask;
  assign low = vis & (~vis + 1'b1);
  assign sum = {1'b0, vis} + {1'b0, low};
  assign run = vis & ~sum[XW-1:0];

  assign dn_addr = ROW_W'(row_r + ROW_W'(yy_r));
  assign res_go  = !ov_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          unique case (cmd.op)
            OP_ADD, OP_DEL: state_nxt = cmd.ok ? B_MK_RD : B_RES;
            OP_CLR:         state_nxt = B_RES;
            OP_GET:         state_nxt = (cmd.rows == '0) ? B_RES : B_SC_RD;
            default:        state_nxt = B_RES;
          endcase
        end
      end
      B_MK_RD: state_nxt = B_MK_WR;
      B_MK_WR: state_nxt = (row_r == cmd_r.r2) ? B_RES : B_MK_RD;
      B_SC_RD: state_nxt = B_SC_EV;
      B_SC_EV: begin
        if (vis != '0) begin
          state_nxt = B_DN_CHK;
        end else if ((NROW_W+1)'(row_r) + 1'b1 >= (NROW_W+1)'(cmd_r.rows)) begin
          state_nxt = B_RES;
        end else begin
          state_nxt = B_SC_RD;
        end
      end
      B_DN_CHK: begin
        if ((NROW_W+1)'(row_r) + (NROW_W+1)'(yy_r) < (NROW_W+1)'(cmd_r.rows)) begin
          state_nxt = B_DN_RD;
        end else begin
          state_nxt = B_GET_FIN;
        end
      end
      B_DN_RD:   state_nxt = B_DN_EV;
      B_DN_EV:   state_nxt = ((row_data & m_r) == m_r) ? B_DN_CHK : B_GET_FIN;
      B_GET_FIN: state_nxt = B_RES;
      B_RES:     if (res_go) state_nxt = B_IDLE;
      default:   state_nxt = B_IDLE;
    endcase
  end

  // outputs: queue pop and RAM port control
  always_comb begin
    pop       = (state_r == B_IDLE) && !empty;
    ram_we    = 1'b0;
    ram_waddr = row_r;
    ram_wdata = row_data;
    ram_raddr = row_r;
    unique case (state_r)
      B_MK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (cmd_r.op == OP_ADD) ? (row_data | mk) : (row_data & ~mk);
      end
      B_SC_EV: begin
        ram_we    = (vis != '0);
        ram_wdata = row_data & ~run;
      end
      B_DN_RD: ram_raddr = dn_addr;
      B_DN_EV: begin
        ram_we    = ((row_data & m_r) == m_r);
        ram_waddr = dn_addr;
        ram_wdata = row_data & ~m_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // state, valid bits and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      vld_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE && !empty && cmd.op == OP_CLR) begin
        vld_r <= '0;
      end else if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (state_r == B_RES && res_go) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // result products
  assign nc   = NCOL_W'(cmd_r.c2) - NCOL_W'(cmd_r.c1) + 1'b1;
  assign nr   = NROW_W'(cmd_r.r2) - NROW_W'(cmd_r.r1) + 1'b1;
  assign prod = (NCOL_W+NROW_W)'(nc) * (NCOL_W+NROW_W)'(nr);
  assign px   = (COL_W+9)'(x_r) * (COL_W+9)'(cmd_r.tw);
  assign py   = (ROW_W+9)'(row_r) * (ROW_W+9)'(cmd_r.th);
  assign pw   = (NCOL_W+9)'(xx_r) * (NCOL_W+9)'(cmd_r.tw);
  assign ph   = (NROW_W+9)'(yy_r) * (NROW_W+9)'(cmd_r.th);

  // command datapath
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[ram_raddr];
    unique case (state_r)
      B_IDLE: begin
        cmd_r   <= cmd;
        found_r <= 1'b0;
        row_r   <= (cmd.op == OP_GET) ? '0 : cmd.r1;
      end
      B_MK_WR: row_r <= row_r + 1'b1;
      B_SC_EV: begin
        if (vis != '0) begin
          m_r     <= run;
          low_r   <= low;
          end_r   <= sum & ~{1'b0, vis};
          yy_r    <= NROW_W'(1);
          found_r <= 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end
      B_DN_EV: if ((row_data & m_r) == m_r) yy_r <= yy_r + 1'b1;
      B_GET_FIN: begin
        x_r  <= COL_W'(enc({1'b0, low_r}));
        xx_r <= enc(end_r) - enc({1'b0, low_r});
      end
      default: row_r <= row_r;
    endcase
    if (state_r == B_RES && res_go) begin
      f_o_r   <= found_r;
      cnt_o_r <= (cmd_r.ok && (cmd_r.op == OP_ADD || cmd_r.op == OP_DEL))
                 ? 13'(sat32(32'(prod), 32'd8191)) : '0;
      x_o_r   <= found_r ? 14'(sat32(32'(px), 32'd16383)) : '0;
      y_o_r   <= found_r ? 14'(sat32(32'(py), 32'd16383)) : '0;
      w_o_r   <= found_r ? 15'(sat32(32'(pw), 32'd32767)) : '0;
      h_o_r   <= found_r ? 15'(sat32(32'(ph), 32'd32767)) : '0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = f_o_r;
  assign out_tdata  = {1'b0, h_o_r, w_o_r, y_o_r, x_o_r, cnt_o_r};

endmodule

// ===== hw/rtl/dtt_checker.sv =====
// Port-level checks of the dirty tile tracker, bound to the top level.
module dtt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // no rectangle without found
  a_nofound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[71:13] == '0)
    else $error("rectangle fields set without found");

  // a found rectangle has a size and no tile count
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[12:0] == '0 && out_tdata[55:41] != '0 && out_tdata[70:56] != '0)
    else $error("found rectangle malformed");

  // reset drops the result
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dirty_tile_tracker_core dtt_checker u_chk (.*);
